### design/quaternion_to_euler_angles_unit_assert.svh
// Assertion macros for the quaternion to Euler angle converter.
// Used by design/quaternion_to_euler_angles_unit.sv; expects clk and rst_n in scope.
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define QTE_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define QTE_ASSERT_IMP(lbl, pre, post)
`define QTE_ASSERT_NXT(lbl, pre, post)
`endif
`endif

### design/qte_pkg.sv
// Shared widths, types, constants and helper functions for the quaternion
// to Euler angle converter. No dependencies.
package qte_pkg;

    localparam int QUAT_W        = 16;
    localparam int PROD_W        = 32;
    localparam int ARG_W         = 34;
    localparam int CORD_W        = 37;
    localparam int ANG_W         = 26;
    localparam int RAD_W         = 61;
    localparam int ROOT_W        = 31;
    localparam int SIN_W         = 31;
    localparam int RES_W         = 17;
    localparam int SQRT_STAGES   = 31;
    localparam int CORDIC_STEPS  = 18;
    localparam int CORDIC_STAGES = CORDIC_STEPS + 1;
    localparam int PIPE_DEPTH    = 4 + SQRT_STAGES + CORDIC_STAGES + 1;

    typedef logic signed [ARG_W-1:0]  arg_t;
    typedef logic signed [CORD_W-1:0] cord_t;
    typedef logic signed [ANG_W-1:0]  ang_t;
    typedef logic signed [RES_W-1:0]  res_t;

    localparam arg_t ONE_Q30   = 34'sd1073741824;
    localparam ang_t HALF_TURN = 26'sd11796480;
    localparam res_t LIM_FULL  = 17'sd23040;
    localparam res_t LIM_HALF  = 17'sd11520;

    typedef struct packed {
        arg_t                     roll_y;
        arg_t                     roll_x;
        arg_t                     yaw_y;
        arg_t                     yaw_x;
        logic signed [SIN_W-1:0]  sinp;
        logic                     sat_pos;
        logic                     sat_neg;
    } side_t;

    // Arctangent of 2^-i in units of 2^-16 degree, rounded to nearest.
    function automatic ang_t atan_step(input logic [4:0] idx);
        ang_t val;
        unique case (idx)
            5'd0:    val = 26'sd2949120;
            5'd1:    val = 26'sd1740967;
            5'd2:    val = 26'sd919879;
            5'd3:    val = 26'sd466945;
            5'd4:    val = 26'sd234379;
            5'd5:    val = 26'sd117304;
            5'd6:    val = 26'sd58666;
            5'd7:    val = 26'sd29335;
            5'd8:    val = 26'sd14668;
            5'd9:    val = 26'sd7334;
            5'd10:   val = 26'sd3667;
            5'd11:   val = 26'sd1833;
            5'd12:   val = 26'sd917;
            5'd13:   val = 26'sd458;
            5'd14:   val = 26'sd229;
            5'd15:   val = 26'sd115;
            5'd16:   val = 26'sd57;
            5'd17:   val = 26'sd29;
            default: val = '0;
        endcase
        return val;
    endfunction

    // Round half up to 1/128 degree and clamp to +-lim.
    function automatic res_t round_clamp(input ang_t ang, input res_t lim);
        ang_t sum;
        res_t r;
        sum = ang + 26'sd256;
        r   = res_t'(sum >>> 9);
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

### design/quaternion_to_euler_angles_unit.sv
// Quaternion (Q1.15) to ZYX roll, pitch and yaw in 1/128 degree steps. One
// quaternion enters per clock cycle unless the result is stalled. It passes
// product, sum, squaring and 1 - s^2 registers, a 31-stage square-root pipeline
// for the pitch cosine, a fold stage, 18 CORDIC stages and one rounding stage.
// A stalled result holds the whole pipeline; stages take no stall of their own.
// Depends on qte_pkg, qte_sqrt, qte_cordic and the assertion macro header.
`include "quaternion_to_euler_angles_unit_assert.svh"

module quaternion_to_euler_angles_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle
);

    localparam int PW = qte_pkg::PROD_W;
    localparam int AW = qte_pkg::ARG_W;
    localparam int CW = qte_pkg::CORD_W;

    logic                          adv;
    logic [qte_pkg::PIPE_DEPTH-1:0] vld_reg;

    // Stage 1: component products.
    logic signed [PW-1:0] wx_reg, yz_reg, wz_reg, xy_reg, wy_reg, zx_reg;
    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg;
    // Stage 2: atan2 arguments and pitch sine.
    qte_pkg::arg_t roll_y_reg, roll_x_reg, yaw_y_reg, yaw_x_reg, sinp_reg;
    logic          sat_pos_reg, sat_neg_reg;
    qte_pkg::arg_t sinp_next;
    // Stages 3 and 4: sine squared, then 1 - s^2.
    logic signed [2*qte_pkg::SIN_W-1:0] sq_prod;
    logic [qte_pkg::RAD_W-1:0]          sq_reg;
    logic [qte_pkg::RAD_W-1:0]          rad_reg;
    qte_pkg::side_t                     side3_reg;
    qte_pkg::side_t                     side4_reg;
    qte_pkg::side_t                     side3_next;
    // Side data that runs alongside the square root and the CORDIC stages.
    qte_pkg::side_t               dly_reg [qte_pkg::SQRT_STAGES];
    logic [1:0]                   sat_dly_reg [qte_pkg::CORDIC_STAGES];
    logic [qte_pkg::ROOT_W-1:0]   root;
    qte_pkg::side_t               dly_out;
    qte_pkg::ang_t                roll_ang, pitch_ang, yaw_ang;
    logic [1:0]                   sat_out;
    qte_pkg::res_t                roll_r, pitch_r, yaw_r;
    logic signed [15:0]           roll_reg, yaw_reg;
    logic signed [14:0]           pitch_reg;

    assign adv      = !vld_reg[qte_pkg::PIPE_DEPTH-1] || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[qte_pkg::PIPE_DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            wy_reg <= quat_w * quat_y;
            zx_reg <= quat_z * quat_x;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
        end
    end

    assign sinp_next = (AW'(wy_reg) - AW'(zx_reg)) <<< 1;

    always_ff @(posedge clk)
    begin
        if (adv) begin
            roll_y_reg  <= (AW'(wx_reg) + AW'(yz_reg)) <<< 1;
            roll_x_reg  <= qte_pkg::ONE_Q30 - ((AW'(xx_reg) + AW'(yy_reg)) <<< 1);
            yaw_y_reg   <= (AW'(wz_reg) + AW'(xy_reg)) <<< 1;
            yaw_x_reg   <= qte_pkg::ONE_Q30 - ((AW'(yy_reg) + AW'(zz_reg)) <<< 1);
            sinp_reg    <= sinp_next;
            sat_pos_reg <= sinp_next >= qte_pkg::ONE_Q30;
            sat_neg_reg <= sinp_next <= -qte_pkg::ONE_Q30;
        end
    end

    // Outside saturation the sine fits in 31 bits, so only those are squared.
    always_comb
    begin
        side3_next.roll_y  = roll_y_reg;
        side3_next.roll_x  = roll_x_reg;
        side3_next.yaw_y   = yaw_y_reg;
        side3_next.yaw_x   = yaw_x_reg;
        side3_next.sinp    = sinp_reg[qte_pkg::SIN_W-1:0];
        side3_next.sat_pos = sat_pos_reg;
        side3_next.sat_neg = sat_neg_reg;
    end

    assign sq_prod = side3_next.sinp * side3_next.sinp;

    always_ff @(posedge clk)
    begin
        if (adv) begin
            sq_reg    <= sq_prod[qte_pkg::RAD_W-1:0];
            side3_reg <= side3_next;
            rad_reg   <= (qte_pkg::RAD_W'(1) << (qte_pkg::RAD_W - 1)) - sq_reg;
            side4_reg <= side3_reg;
        end
    end

    qte_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (rad_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv) begin
            dly_reg[0] <= side4_reg;
            for (int i = 1; i < qte_pkg::SQRT_STAGES; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dly_out = dly_reg[qte_pkg::SQRT_STAGES-1];

    qte_cordic u_roll (
        .clk     (clk),
        .en      (adv),
        .y_in    (CW'(dly_out.roll_y)),
        .x_in    (CW'(dly_out.roll_x)),
        .ang_out (roll_ang)
    );

    qte_cordic u_pitch (
        .clk     (clk),
        .en      (adv),
        .y_in    (CW'(dly_out.sinp)),
        .x_in    (qte_pkg::cord_t'(root)),
        .ang_out (pitch_ang)
    );

    qte_cordic u_yaw (
        .clk     (clk),
        .en      (adv),
        .y_in    (CW'(dly_out.yaw_y)),
        .x_in    (CW'(dly_out.yaw_x)),
        .ang_out (yaw_ang)
    );

    always_ff @(posedge clk)
    begin
        if (adv) begin
            sat_dly_reg[0] <= {dly_out.sat_pos, dly_out.sat_neg};
            for (int i = 1; i < qte_pkg::CORDIC_STAGES; i++) begin
                sat_dly_reg[i] <= sat_dly_reg[i-1];
            end
        end
    end

    assign sat_out = sat_dly_reg[qte_pkg::CORDIC_STAGES-1];

    always_comb
    begin
        roll_r = qte_pkg::round_clamp(roll_ang, qte_pkg::LIM_FULL);
        yaw_r  = qte_pkg::round_clamp(yaw_ang, qte_pkg::LIM_FULL);
        priority if (sat_out[1]) begin
            pitch_r = qte_pkg::LIM_HALF;
        end else if (sat_out[0]) begin
            pitch_r = -qte_pkg::LIM_HALF;
        end else begin
            pitch_r = qte_pkg::round_clamp(pitch_ang, qte_pkg::LIM_HALF);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            roll_reg  <= roll_r[15:0];
            pitch_reg <= pitch_r[14:0];
            yaw_reg   <= yaw_r[15:0];
        end
    end

    assign out_valid   = vld_reg[qte_pkg::PIPE_DEPTH-1];
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;

    `QTE_ASSERT_IMP(a_pitch_range, out_valid, (pitch_angle <= 15'sd11520) && (pitch_angle >= -15'sd11520))
    `QTE_ASSERT_IMP(a_roll_range, out_valid, (roll_angle <= 16'sd23040) && (roll_angle >= -16'sd23040))
    `QTE_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld_reg[0])
    `QTE_ASSERT_IMP(a_sat_exclusive, vld_reg[1], !(sat_pos_reg && sat_neg_reg))

endmodule

### design/qte_sqrt.sv
// Pipelined bit-by-bit floor square root, one result bit per stage.
// Depends on qte_pkg.
module qte_sqrt (
    input  logic                           clk,
    input  logic                           en,
    input  logic [qte_pkg::RAD_W-1:0]      rad,
    output logic [qte_pkg::ROOT_W-1:0]     root
);

    logic [qte_pkg::RAD_W-1:0] rem_reg [qte_pkg::SQRT_STAGES];
    logic [qte_pkg::RAD_W-1:0] res_reg [qte_pkg::SQRT_STAGES];

    for (genvar k = 0; k < qte_pkg::SQRT_STAGES; k++) begin : g_stage
        localparam logic [qte_pkg::RAD_W-1:0] BIT_VAL =
            qte_pkg::RAD_W'(1) << (qte_pkg::RAD_W - 1 - 2 * k);
        logic [qte_pkg::RAD_W-1:0] rem_in;
        logic [qte_pkg::RAD_W-1:0] res_in;
        logic [qte_pkg::RAD_W-1:0] trial;
        logic [qte_pkg::RAD_W-1:0] rem_next;
        logic [qte_pkg::RAD_W-1:0] res_next;

        if (k == 0) begin : g_first
            assign rem_in = rad;
            assign res_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + BIT_VAL;
            if (rem_in >= trial) begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT_VAL;
            end else begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign root = res_reg[qte_pkg::SQRT_STAGES-1][qte_pkg::ROOT_W-1:0];

endmodule

### design/qte_cordic.sv
// Pipelined CORDIC in vectoring mode: atan2(y, x) in 2^-16 degree units.
// One quadrant-fold stage, then one micro-rotation per stage. Depends on qte_pkg.
module qte_cordic (
    input  logic                 clk,
    input  logic                 en,
    input  qte_pkg::cord_t       y_in,
    input  qte_pkg::cord_t       x_in,
    output qte_pkg::ang_t        ang_out
);

    qte_pkg::cord_t x_reg    [qte_pkg::CORDIC_STAGES];
    qte_pkg::cord_t y_reg    [qte_pkg::CORDIC_STAGES];
    qte_pkg::ang_t  ang_reg  [qte_pkg::CORDIC_STAGES];
    logic           zero_reg [qte_pkg::CORDIC_STAGES];

    // A vector in the left half plane is turned by 180 degrees first.
    always_ff @(posedge clk)
    begin
        if (en) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0) begin
                x_reg[0]   <= -x_in;
                y_reg[0]   <= -y_in;
                ang_reg[0] <= (y_in >= 0) ? qte_pkg::HALF_TURN : -qte_pkg::HALF_TURN;
            end else begin
                x_reg[0]   <= x_in;
                y_reg[0]   <= y_in;
                ang_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin : g_step
        localparam qte_pkg::ang_t STEP_ANG = qte_pkg::atan_step(5'(i));
        qte_pkg::cord_t dx;
        qte_pkg::cord_t dy;

        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1]   <= x_reg[i] + dy;
                    y_reg[i+1]   <= y_reg[i] - dx;
                    ang_reg[i+1] <= ang_reg[i] + STEP_ANG;
                end else begin
                    x_reg[i+1]   <= x_reg[i] - dy;
                    y_reg[i+1]   <= y_reg[i] + dx;
                    ang_reg[i+1] <= ang_reg[i] - STEP_ANG;
                end
            end
        end
    end

    assign ang_out = zero_reg[qte_pkg::CORDIC_STAGES-1] ? '0
                                                         : ang_reg[qte_pkg::CORDIC_STAGES-1];

endmodule

### tb/quaternion_to_euler_angles_unit_tb.sv
// Testbench for quaternion_to_euler_angles_unit: drives random and corner quaternions
// and checks roll, pitch and yaw against a built-in fixed-point CORDIC predictor.
// Depends on the RTL top level only.
module quaternion_to_euler_angles_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } angles_t;

    class angle_scoreboard;
        angles_t pending[$];
        int mismatches;

        function automatic longint fl_shift(longint v, int s);
            return v >>> s;
        endfunction

        function automatic longint isqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function automatic longint vector_angle(longint ya, longint xa);
            longint acc;
            longint dx;
            longint dy;
            longint steps[18];
            acc = 0;
            steps = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
            if (xa == 0 && ya == 0) return 0;
            if (xa < 0)
            begin
                acc = (ya >= 0) ? 64'sd11796480 : -64'sd11796480;
                xa = -xa;
                ya = -ya;
            end
            for (int i = 0; i < 18; i++)
            begin
                dx = fl_shift(xa, i);
                dy = fl_shift(ya, i);
                if (ya >= 0)
                begin
                    xa += dy; ya -= dx; acc += steps[i];
                end
                else
                begin
                    xa -= dy; ya += dx; acc -= steps[i];
                end
            end
            return acc;
        endfunction

        function automatic longint to_degrees128(longint a, longint lim);
            longint r;
            r = fl_shift(a + 256, 9);
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            return r;
        endfunction

        function void note_quaternion(logic signed [15:0] qw, logic signed [15:0] qx,
                                      logic signed [15:0] qy, logic signed [15:0] qz);
            longint w, x, y, z, sinp, one, c;
            angles_t e;
            w = qw; x = qx; y = qy; z = qz;
            one = 64'sd1 << 30;
            e.roll = 16'(to_degrees128(vector_angle(2 * (w * x + y * z),
                                        one - 2 * (x * x + y * y)), 23040));
            e.yaw = 16'(to_degrees128(vector_angle(2 * (w * z + x * y),
                                       one - 2 * (y * y + z * z)), 23040));
            sinp = 2 * (w * y - z * x);
            if (sinp >= one) e.pitch = 15'sd11520;
            else if (sinp <= -one) e.pitch = -15'sd11520;
            else
            begin
                c = isqrt((64'd1 << 60) - longint'(sinp * sinp));
                e.pitch = 15'(to_degrees128(vector_angle(sinp, c), 11520));
            end
            pending.push_back(e);
        endfunction

        function void check_angles(logic signed [15:0] r, logic signed [14:0] p,
                                   logic signed [15:0] yv);
            angles_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result r=%0d p=%0d y=%0d", r, p, yv);
                return;
            end
            e = pending.pop_front();
            if (r !== e.roll || p !== e.pitch || yv !== e.yaw)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected r=%0d p=%0d y=%0d, got r=%0d p=%0d y=%0d",
                             e.roll, e.pitch, e.yaw, r, p, yv);
            end
        endfunction
    endclass

    localparam int LATENCY = 55;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] quat_w = '0;
    logic signed [15:0] quat_x = '0;
    logic signed [15:0] quat_y = '0;
    logic signed [15:0] quat_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;

    angle_scoreboard board = new();
    bit stimulus_done = 0;
    bit hold_output = 0;

    quaternion_to_euler_angles_unit dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Valid stays high between back-to-back transfers; it drops only for a gap.
    task automatic send_quaternion(logic signed [15:0] w, logic signed [15:0] x,
                                   logic signed [15:0] y, logic signed [15:0] z);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
        do @(posedge clk); while (in_stall);
        board.note_quaternion(w, x, y, z);
    endtask

    // Random unit-ish quaternion: each component drawn freely or shaped small
    // or large at random so that every region of the angle space is reached.
    function automatic logic signed [15:0] rand_part();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 2000)) - 1000);
            2: return 16'($signed($urandom_range(0, 46340)) - 23170);
            default: return 16'($signed($urandom_range(0, 33000)) - 16500);
        endcase
    endfunction

    task automatic send_unit();
        real a, b, c, d, n;
        a = $signed(rand_part()); b = $signed(rand_part());
        c = $signed(rand_part()); d = $signed(rand_part());
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        send_quaternion(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
                        16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)));
    endtask

    initial
    begin
        logic signed [15:0] corners[5];
        corners = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh5A82};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Identity, axis turns, gimbal lock at both signs, zero quaternion, extremes.
        send_quaternion(16'sh7FFF, 0, 0, 0);
        send_quaternion(0, 16'sh7FFF, 0, 0);
        send_quaternion(0, 0, 16'sh7FFF, 0);
        send_quaternion(0, 0, 0, 16'sh7FFF);
        send_quaternion(16'sh5A82, 0, 16'sh5A82, 0);
        send_quaternion(16'sh5A82, 0, 16'shA57E, 0);
        send_quaternion(0, 0, 0, 0);
        send_quaternion(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quaternion(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        for (int i = 0; i < 14; i++)
            send_quaternion(corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)],
                            corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)]);
        in_valid <= 1'b0;
        // Pause until the pipeline has drained.
        while (board.pending.size() != 0) @(posedge clk);
        for (int i = 0; i < 1700; i++)
        begin
            if (i == 300) hold_output = 1;
            if (i % 8 == 0) send_quaternion(16'($urandom), 16'($urandom),
                                            16'($urandom), 16'($urandom));
            else send_unit();
        end
        in_valid <= 1'b0;
        stimulus_done = 1;
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off.
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                hold_output = 0;
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_angles(roll_angle, pitch_angle, yaw_angle);

    initial
    begin
        wait (stimulus_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("** quaternion_to_euler_angles_unit: PASSED **");
        else
            $display("** quaternion_to_euler_angles_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("** quaternion_to_euler_angles_unit: FAILED **");
        $finish;
    end
endmodule

### sim.f
+incdir+design
design/qte_pkg.sv
design/qte_sqrt.sv
design/qte_cordic.sv
design/quaternion_to_euler_angles_unit.sv
tb/quaternion_to_euler_angles_unit_tb.sv
